// File: sv/bezier_curve_tessellator_core_macros.svh
// Assertion macros used by the curve tessellator evaluator.
`ifndef BEZIER_CURVE_TESSELLATOR_CORE_MACROS_SVH
`define BEZIER_CURVE_TESSELLATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/bct_pkg.sv
// Shared constants and types of the curve tessellator.
package bct_pkg;
    localparam int MAX_SEGMENTS = 63;
    localparam int CNT_W        = 6;
    localparam int COORD_W      = 16;
    localparam int T_W          = 17;
    localparam int R_W          = CNT_W + 1;
    localparam int DIV_W        = T_W + 1;
    localparam int DIV_CNT_W    = 5;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int NPTS         = 4;
    localparam int K_W          = 2;
    localparam int SQ_W         = 2 * T_W - 1;
    localparam int W_W          = 50;
    localparam int PROD_W       = W_W + T_W;
    localparam int ACC_W        = 64;

    localparam logic [T_W-1:0]     T_ONE     = 17'h10000;
    localparam logic [COORD_W-1:0] SIGN_FLIP = 16'h8000;
    localparam logic [ACC_W-1:0]   RND_QUAD  = 64'h0000_0000_8000_0000;
    localparam logic [ACC_W-1:0]   RND_CUBIC = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic                             cubic;
        logic [CNT_W-1:0]                 n;
        logic [T_W-1:0]                   q_step;
        logic [R_W-1:0]                   r_step;
        logic [NPTS-1:0][COORD_W-1:0]     px;
        logic [NPTS-1:0][COORD_W-1:0]     py;
    } t_job;
endpackage

// File: sv/bct_if.sv
// Handshake interfaces for the curve input and segment output channels.
interface bct_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [15:0] p1_x;
    logic signed [15:0] p1_y;
    logic signed [15:0] p2_x;
    logic signed [15:0] p2_y;
    logic signed [15:0] p3_x;
    logic signed [15:0] p3_y;
    logic signed [15:0] p4_x;
    logic signed [15:0] p4_y;
    logic        [5:0]  segments;

    modport source (output valid, mode, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
                    segments, input ready);
    modport sink (input valid, mode, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
                  segments, output ready);
endinterface

interface bct_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               last;

    modport source (output valid, start_x, start_y, end_x, end_y, last, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, last, output ready);
endinterface

// File: sv/bct_front.sv
// Front end: accepts a curve, clamps the count and derives the t step by division.
module bct_front
    import bct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bct_in_if.sink     i_in,
    output t_job       o_job,
    output logic       o_job_valid,
    input  logic       i_job_ready
);
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;

    t_state                       r_state;
    logic                         r_cubic;
    logic [CNT_W-1:0]             r_n;
    logic [NPTS-1:0][COORD_W-1:0] r_px;
    logic [NPTS-1:0][COORD_W-1:0] r_py;
    logic [R_W-1:0]               r_div_d;
    logic [R_W-1:0]               r_rem;
    logic [DIV_W-1:0]             r_quo;
    logic [DIV_CNT_W-1:0]         r_cnt;

    logic [CNT_W-1:0]             n_n;
    logic [R_W:0]                 n_rem_sh;

    always_comb begin
        if (i_in.segments == '0) begin
            n_n = CNT_W'(1);
        end else if (i_in.segments > CNT_W'(MAX_SEGMENTS)) begin
            n_n = CNT_W'(MAX_SEGMENTS);
        end else begin
            n_n = i_in.segments;
        end
        n_rem_sh = {r_rem, (r_cnt == DIV_CNT_W'(DIV_W - 1))};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cubic <= i_in.mode;
                        r_n     <= n_n;
                        r_px[0] <= $unsigned(i_in.p1_x) ^ SIGN_FLIP;
                        r_px[1] <= $unsigned(i_in.p2_x) ^ SIGN_FLIP;
                        r_px[2] <= $unsigned(i_in.p3_x) ^ SIGN_FLIP;
                        r_px[3] <= $unsigned(i_in.p4_x) ^ SIGN_FLIP;
                        r_py[0] <= $unsigned(i_in.p1_y) ^ SIGN_FLIP;
                        r_py[1] <= $unsigned(i_in.p2_y) ^ SIGN_FLIP;
                        r_py[2] <= $unsigned(i_in.p3_y) ^ SIGN_FLIP;
                        r_py[3] <= $unsigned(i_in.p4_y) ^ SIGN_FLIP;
                        r_div_d <= {n_n, 1'b0};
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= DIV_CNT_W'(DIV_W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (n_rem_sh >= {1'b0, r_div_d}) begin
                        r_rem <= R_W'(n_rem_sh - {1'b0, r_div_d});
                        r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rem_sh[R_W-1:0];
                        r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (i_job_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        i_in.ready   = (r_state == S_IDLE);
        o_job_valid  = (r_state == S_PUSH);
        o_job.cubic  = r_cubic;
        o_job.n      = r_n;
        o_job.q_step = r_quo[T_W-1:0];
        o_job.r_step = r_rem;
        o_job.px     = r_px;
        o_job.py     = r_py;
    end
endmodule

// File: sv/bct_queue.sv
// Two-entry job queue between the front end and the evaluator.
module bct_queue
    import bct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_push_valid,
    output logic o_push_ready,
    output t_job o_job,
    output logic o_pop_valid,
    input  logic i_pop
);
    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W:0]   r_count;

    logic              n_push;
    logic              n_pop;
    logic [QPTR_W-1:0] n_tail;

    always_comb begin
        o_push_ready = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
        o_pop_valid  = (r_count != '0);
        n_push       = i_push_valid && o_push_ready;
        n_pop        = i_pop && o_pop_valid;
        n_tail       = QPTR_W'(r_head + r_count[QPTR_W-1:0]);
        o_job        = r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (n_push) begin
                r_mem[n_tail] <= i_job;
            end
            if (n_pop) begin
                r_head <= r_head + 1'b1;
            end
            r_count <= r_count + (QPTR_W + 1)'(n_push) - (QPTR_W + 1)'(n_pop);
        end
    end
endmodule

// File: sv/bct_back.sv
// Evaluator: steps t over the curve, blends the control points and emits segments.
module bct_back
    import bct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_job_valid,
    output logic        o_job_pop,
    bct_out_if.source   o_out
);
`include "bezier_curve_tessellator_core_macros.svh"

    typedef enum logic [2:0] {S_IDLE, S_W1, S_W2, S_W3, S_W4, S_ACC, S_EMIT} t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_i;
    logic [T_W-1:0]         r_q;
    logic [R_W-1:0]         r_r;
    logic [K_W-1:0]         r_k;
    logic [SQ_W-1:0]        r_uu;
    logic [SQ_W-1:0]        r_ut;
    logic [SQ_W-1:0]        r_tt;
    logic [W_W-1:0]         r_w [NPTS];
    logic [ACC_W-1:0]       r_acc_x;
    logic [ACC_W-1:0]       r_acc_y;
    logic [COORD_W-1:0]     r_prev_x;
    logic [COORD_W-1:0]     r_prev_y;
    logic                   r_out_valid;
    logic [COORD_W-1:0]     r_start_x;
    logic [COORD_W-1:0]     r_start_y;
    logic [COORD_W-1:0]     r_end_x;
    logic [COORD_W-1:0]     r_end_y;
    logic                   r_last;

    logic [T_W-1:0]         n_u;
    logic [R_W-1:0]         n_two_n;
    logic [W_W-1:0]         n_a_x;
    logic [W_W-1:0]         n_a_y;
    logic [T_W-1:0]         n_b_x;
    logic [T_W-1:0]         n_b_y;
    logic [PROD_W-1:0]      n_prod_x;
    logic [PROD_W-1:0]      n_prod_y;
    logic [COORD_W-1:0]     n_cur_x;
    logic [COORD_W-1:0]     n_cur_y;
    logic                   n_out_free;
    logic                   n_emit;
    logic                   n_is_last;
    logic [R_W:0]           n_rsum;
    logic [K_W-1:0]         n_k_end;

    always_comb begin
        n_u     = T_ONE - r_q;
        n_two_n = {i_job.n, 1'b0};
        n_a_x   = '0;
        n_a_y   = '0;
        n_b_x   = '0;
        n_b_y   = '0;
        case (r_state)
            S_W1: begin
                n_a_x = W_W'(n_u);
                n_b_x = n_u;
                n_a_y = W_W'(n_u);
                n_b_y = r_q;
            end
            S_W2: begin
                n_a_x = W_W'(r_q);
                n_b_x = r_q;
            end
            S_W3: begin
                n_a_x = W_W'(r_uu);
                n_b_x = n_u;
                n_a_y = W_W'(r_uu);
                n_b_y = r_q;
            end
            S_W4: begin
                n_a_x = W_W'(r_tt);
                n_b_x = n_u;
                n_a_y = W_W'(r_tt);
                n_b_y = r_q;
            end
            S_ACC: begin
                n_a_x = r_w[r_k];
                n_b_x = {1'b0, i_job.px[r_k]};
                n_a_y = r_w[r_k];
                n_b_y = {1'b0, i_job.py[r_k]};
            end
            default: begin
                n_a_x = '0;
            end
        endcase
        n_prod_x = PROD_W'(n_a_x) * PROD_W'(n_b_x);
        n_prod_y = PROD_W'(n_a_y) * PROD_W'(n_b_y);
        if (i_job.cubic) begin
            n_cur_x = r_acc_x[63:48] ^ SIGN_FLIP;
            n_cur_y = r_acc_y[63:48] ^ SIGN_FLIP;
            n_k_end = K_W'(3);
        end else begin
            n_cur_x = r_acc_x[47:32] ^ SIGN_FLIP;
            n_cur_y = r_acc_y[47:32] ^ SIGN_FLIP;
            n_k_end = K_W'(2);
        end
        n_out_free = !r_out_valid || o_out.ready;
        n_emit     = (r_state == S_EMIT) && n_out_free;
        n_is_last  = (r_i == i_job.n);
        n_rsum     = {1'b0, r_r} + {1'b0, i_job.r_step};
        o_job_pop  = n_emit && n_is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && !n_emit) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_i     <= '0;
                        r_q     <= '0;
                        r_r     <= {1'b0, i_job.n};
                        r_state <= S_W1;
                    end
                end
                S_W1: begin
                    r_uu    <= SQ_W'(n_prod_x);
                    r_ut    <= SQ_W'(n_prod_y);
                    r_acc_x <= i_job.cubic ? RND_CUBIC : RND_QUAD;
                    r_acc_y <= i_job.cubic ? RND_CUBIC : RND_QUAD;
                    r_state <= S_W2;
                end
                S_W2: begin
                    r_tt    <= SQ_W'(n_prod_x);
                    r_state <= S_W3;
                end
                S_W3: begin
                    r_k <= '0;
                    if (i_job.cubic) begin
                        r_w[0]  <= W_W'(n_prod_x);
                        r_w[1]  <= W_W'(n_prod_y) + W_W'({n_prod_y, 1'b0});
                        r_state <= S_W4;
                    end else begin
                        r_w[0]  <= W_W'(r_uu);
                        r_w[1]  <= W_W'({r_ut, 1'b0});
                        r_w[2]  <= W_W'(r_tt);
                        r_w[3]  <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_W4: begin
                    r_w[2]  <= W_W'(n_prod_x) + W_W'({n_prod_x, 1'b0});
                    r_w[3]  <= W_W'(n_prod_y);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc_x <= r_acc_x + n_prod_x[ACC_W-1:0];
                    r_acc_y <= r_acc_y + n_prod_y[ACC_W-1:0];
                    r_k     <= r_k + 1'b1;
                    if (r_k == n_k_end) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (n_out_free) begin
                        r_out_valid <= 1'b1;
                        r_start_x   <= (r_i == '0) ? n_cur_x : r_prev_x;
                        r_start_y   <= (r_i == '0) ? n_cur_y : r_prev_y;
                        r_end_x     <= n_cur_x;
                        r_end_y     <= n_cur_y;
                        r_last      <= n_is_last;
                        r_prev_x    <= n_cur_x;
                        r_prev_y    <= n_cur_y;
                        if (n_is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + 1'b1;
                            if (n_rsum >= {1'b0, n_two_n}) begin
                                r_r <= R_W'(n_rsum - {1'b0, n_two_n});
                                r_q <= r_q + i_job.q_step + 1'b1;
                            end else begin
                                r_r <= n_rsum[R_W-1:0];
                                r_q <= r_q + i_job.q_step;
                            end
                            r_state <= S_W1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_out.valid   = r_out_valid;
        o_out.start_x = $signed(r_start_x);
        o_out.start_y = $signed(r_start_y);
        o_out.end_x   = $signed(r_end_x);
        o_out.end_y   = $signed(r_end_y);
        o_out.last    = r_last;
    end

    `BCT_ASSERT_IMP(a_busy_has_job, i_clk, i_rst_n, r_state != S_IDLE, i_job_valid, "Evaluator busy without a queued job.")
    `BCT_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, r_state != S_IDLE, r_r < n_two_n, "Step remainder out of range.")
    `BCT_ASSERT_IMP(a_last_at_one, i_clk, i_rst_n, o_job_pop, r_q == T_ONE, "Last segment not at t equal to one.")
    `BCT_ASSERT_NXT(a_pop_marks_last, i_clk, i_rst_n, o_job_pop, r_out_valid && r_last, "Job retired without a last segment.")
endmodule

// File: sv/bezier_curve_tessellator_core.sv
// Top level of the Bezier curve tessellator: front end, job queue and evaluator.
// Usage:
// The input channel i_in takes one curve per item: mode (0 quadratic, 1 cubic),
// four control points in signed Q12.4 and a subdivision count n (0 counts as 1).
// The output channel o_out gives n + 1 segment items per curve in order of t,
// the first of zero length, the one at t equal to one flagged by last.
// The front end accepts a curve, runs a restoring division that sets the t step
// and then hands the curve to a two-entry queue, so i_in.ready stays low from
// each accepted item until the queue takes that curve.
// The evaluator shares one pair of multipliers per sample: it forms the blending
// weights of t, accumulates the weighted control points (three for a quadratic
// curve, four for a cubic one) and then emits the segment.
// The front end works on the next curve while the evaluator runs the current one.
// When the receiver stalls, the finished segment waits in the output register,
// the evaluator holds in its emit step, the queue fills up and the front end
// then holds its curve, keeping i_in.ready low.
// Reset is synchronous and active low; it empties the queue and the output register.
module bezier_curve_tessellator_core
    import bct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bct_in_if.sink     i_in,
    bct_out_if.source  o_out
);
    t_job front_job;
    logic front_valid;
    logic front_ready;
    t_job back_job;
    logic back_valid;
    logic back_pop;

    bct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready)
    );

    bct_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (front_job),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .o_job        (back_job),
        .o_pop_valid  (back_valid),
        .i_pop        (back_pop)
    );

    bct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (back_job),
        .i_job_valid (back_valid),
        .o_job_pop   (back_pop),
        .o_out       (o_out)
    );
endmodule
